// ===== sv/scp_pkg.sv =====
// ----------------------------------------------------------------------------
// scp_pkg
// Shared constants, types and table functions of the Sierpinski curve
// segment generator.
// ----------------------------------------------------------------------------
package scp_pkg;

    localparam int MAX_ORDER = 8;                 // deepest recursion supported
    localparam int ORDER_W   = 4;                 // curve_order field width
    localparam int LEN_W     = 16;                // initial_length field width
    localparam int COORD_W   = 32;                // coordinate width
    localparam int DIR_W     = 3;                 // direction code width
    localparam int FRAC_W    = 8;                 // coordinate fraction bits
    localparam int LVL_W     = $clog2(MAX_ORDER + 1);
    localparam int IDX_W     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int QUO_W     = LEN_W - 1;         // step = (len / 2) / order
    localparam int CNT_W     = $clog2(QUO_W);
    localparam int DIAG_MUL  = 181;               // 256 * sqrt(2) / 2
    localparam int DIAG_W    = QUO_W + 8;
    localparam int AXIS_W    = QUO_W + FRAC_W + 1;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = LEN_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_ORDER    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_LENGTH = 1'b1;

    // curve types and the last move phase of a type
    localparam logic [1:0] KIND_A     = 2'd0;
    localparam logic [1:0] PHASE_LAST = 2'd3;

    typedef logic [1:0] kind_t;
    typedef logic [1:0] phase_t;
    typedef logic [DIR_W-1:0] dir_t;

    typedef struct packed {
        phase_t phase;
        kind_t  kind;
    } stack_entry_t;

    typedef struct packed {
        logic start;      // restart: latch config, clear walk, start divide
        logic div_step;   // one quotient bit
        logic push;       // push one child level
        logic pop;        // drop one finished level
        logic step;       // emit one segment
    } scp_cmd_t;

    typedef struct packed {
        logic active;     // a curve is in progress
        logic div_last;   // divider is on its final bit
        logic can_push;   // stack is above the leaf level
        logic top_done;   // top entry has used all its moves
        logic step_last;  // the pending move is the closing one
    } scp_status_t;

    // move between sub-curves: type k, phase p gives 2k+1-p (mod 8)
    function automatic dir_t kind_move(input kind_t k, input phase_t p);
        dir_t base;
        base = {k, 1'b1};
        return base - dir_t'(p);
    endfunction

    // sub-curve type that follows move phase q of type k
    function automatic kind_t kind_child(input kind_t k, input phase_t q);
        kind_t c;
        case (q)
            2'd1:    c = k + 2'd1;
            2'd2:    c = k + 2'd3;
            default: c = k;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/scp_if.sv =====
// ----------------------------------------------------------------------------
// scp_if
// Valid/ready channels: advance items in, segments out.
// ----------------------------------------------------------------------------
interface scp_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface scp_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [scp_pkg::COORD_W-1:0]   start_x;
    logic signed [scp_pkg::COORD_W-1:0]   start_y;
    logic signed [scp_pkg::COORD_W-1:0]   end_x;
    logic signed [scp_pkg::COORD_W-1:0]   end_y;
    logic        [scp_pkg::DIR_W-1:0]     direction;
    logic                                 last_segment;

    modport source (output valid, output start_x, output start_y, output end_x,
                    output end_y, output direction, output last_segment,
                    input ready);
    modport sink   (input valid, input start_x, input start_y, input end_x,
                    input end_y, input direction, input last_segment,
                    output ready);
endinterface

// ===== sv/scp_dp.sv =====
// ----------------------------------------------------------------------------
// scp_dp
// Datapath: config registers, step divider, type stack, pen position and
// the output register.
// ----------------------------------------------------------------------------
module scp_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [scp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [scp_pkg::CFG_W-1:0]           cfg_wdata,
    input  scp_pkg::scp_cmd_t                   cmd,
    output scp_pkg::scp_status_t                status,
    output logic signed [scp_pkg::COORD_W-1:0]  start_x,
    output logic signed [scp_pkg::COORD_W-1:0]  start_y,
    output logic signed [scp_pkg::COORD_W-1:0]  end_x,
    output logic signed [scp_pkg::COORD_W-1:0]  end_y,
    output logic [scp_pkg::DIR_W-1:0]           direction,
    output logic                                last_segment
);

    logic [scp_pkg::ORDER_W-1:0]  curve_order_reg;
    logic [scp_pkg::LEN_W-1:0]    init_len_reg;

    logic [scp_pkg::LVL_W-1:0]    run_order_reg;
    logic [scp_pkg::LVL_W-1:0]    run_order_next;
    logic [scp_pkg::LVL_W-1:0]    level_reg;
    logic [scp_pkg::LVL_W-1:0]    level_m1;
    logic [scp_pkg::IDX_W-1:0]    top_idx;
    scp_pkg::phase_t              top_phase_reg;
    scp_pkg::kind_t               desc_kind_reg;
    logic                         active_reg;

    scp_pkg::stack_entry_t        type_stack [scp_pkg::MAX_ORDER];
    scp_pkg::stack_entry_t        top_entry;

    // divider
    logic [scp_pkg::QUO_W-1:0]    quo_reg;
    logic [scp_pkg::ORDER_W-1:0]  rem_reg;
    logic [scp_pkg::CNT_W-1:0]    div_cnt_reg;
    logic [scp_pkg::ORDER_W:0]    trial;
    logic                         trial_ge;
    logic [scp_pkg::ORDER_W:0]    trial_sub;

    logic [scp_pkg::DIAG_W-1:0]   diag_reg;
    logic [scp_pkg::AXIS_W-1:0]   axis;

    logic signed [scp_pkg::COORD_W-1:0] pos_x_reg;
    logic signed [scp_pkg::COORD_W-1:0] pos_y_reg;
    logic [scp_pkg::COORD_W-1:0]  diag_ext;
    logic [scp_pkg::COORD_W-1:0]  axis_ext;
    logic [scp_pkg::COORD_W-1:0]  dx;
    logic [scp_pkg::COORD_W-1:0]  dy;

    scp_pkg::dir_t                step_dir;
    logic                         step_last;
    scp_pkg::phase_t              next_phase;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_order_reg <= scp_pkg::ORDER_W'(1);
            init_len_reg    <= scp_pkg::LEN_W'(128);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                scp_pkg::REG_CURVE_ORDER:
                    curve_order_reg <= cfg_wdata[scp_pkg::ORDER_W-1:0];
                scp_pkg::REG_INITIAL_LENGTH:
                    init_len_reg <= cfg_wdata[scp_pkg::LEN_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // order zero runs as one, large orders saturate
    always_comb
    begin
        if (curve_order_reg == '0)
            run_order_next = scp_pkg::LVL_W'(1);
        else if (curve_order_reg > scp_pkg::ORDER_W'(scp_pkg::MAX_ORDER))
            run_order_next = scp_pkg::LVL_W'(scp_pkg::MAX_ORDER);
        else
            run_order_next = scp_pkg::LVL_W'(curve_order_reg);
    end

    assign level_m1  = level_reg - scp_pkg::LVL_W'(1);
    assign top_idx   = level_m1[scp_pkg::IDX_W-1:0];
    assign top_entry = type_stack[top_idx];

    // restoring divide, one quotient bit per cycle
    assign trial     = {rem_reg, quo_reg[scp_pkg::QUO_W-1]};
    assign trial_ge  = trial >= (scp_pkg::ORDER_W+1)'(run_order_reg);
    assign trial_sub = trial - (scp_pkg::ORDER_W+1)'(run_order_reg);

    // move decode
    always_comb
    begin
        step_last  = 1'b0;
        next_phase = '0;
        if (level_reg == '0)
        begin
            step_dir  = {top_phase_reg, 1'b1};
            step_last = (top_phase_reg == scp_pkg::PHASE_LAST);
        end
        else
        begin
            step_dir   = scp_pkg::kind_move(top_entry.kind, top_entry.phase);
            next_phase = top_entry.phase + 2'd1;
        end
    end

    assign axis     = {quo_reg, {(scp_pkg::FRAC_W+1){1'b0}}};
    assign axis_ext = scp_pkg::COORD_W'(axis);
    assign diag_ext = scp_pkg::COORD_W'(diag_reg);

    always_comb
    begin
        case (step_dir)
            3'd0:    begin dx = axis_ext;   dy = '0;        end
            3'd1:    begin dx = diag_ext;   dy = diag_ext;  end
            3'd2:    begin dx = '0;         dy = axis_ext;  end
            3'd3:    begin dx = -diag_ext;  dy = diag_ext;  end
            3'd4:    begin dx = -axis_ext;  dy = '0;        end
            3'd5:    begin dx = -diag_ext;  dy = -diag_ext; end
            3'd6:    begin dx = '0;         dy = -axis_ext; end
            default: begin dx = diag_ext;   dy = -diag_ext; end
        endcase
    end

    // walk control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_order_reg <= scp_pkg::LVL_W'(1);
            level_reg     <= '0;
            top_phase_reg <= '0;
            desc_kind_reg <= scp_pkg::KIND_A;
            active_reg    <= 1'b0;
            div_cnt_reg   <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
        end
        else if (cmd.start)
        begin
            run_order_reg <= run_order_next;
            level_reg     <= '0;
            top_phase_reg <= '0;
            desc_kind_reg <= scp_pkg::KIND_A;
            active_reg    <= 1'b1;
            div_cnt_reg   <= scp_pkg::CNT_W'(scp_pkg::QUO_W - 1);
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
        end
        else
        begin
            if (cmd.div_step)
                div_cnt_reg <= div_cnt_reg - scp_pkg::CNT_W'(1);
            if (cmd.push)
                level_reg <= level_reg + scp_pkg::LVL_W'(1);
            else if (cmd.pop)
                level_reg <= level_m1;
            if (cmd.step)
            begin
                pos_x_reg <= pos_x_reg + $signed(dx);
                pos_y_reg <= pos_y_reg + $signed(dy);
                if (level_reg == '0)
                begin
                    if (step_last)
                        active_reg <= 1'b0;
                    else
                    begin
                        top_phase_reg <= top_phase_reg + 2'd1;
                        desc_kind_reg <= top_phase_reg + 2'd1;
                    end
                end
                else
                    desc_kind_reg <= scp_pkg::kind_child(top_entry.kind, next_phase);
            end
        end
    end

    // type stack, no reset: entries are written before read
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            type_stack[level_reg[scp_pkg::IDX_W-1:0]].kind  <= desc_kind_reg;
            type_stack[level_reg[scp_pkg::IDX_W-1:0]].phase <= '0;
        end
        else if (cmd.step && level_reg != '0)
            type_stack[top_idx].phase <= next_phase;
    end

    // divider payload and the diagonal multiply
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            quo_reg <= init_len_reg[scp_pkg::LEN_W-1:1];
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[scp_pkg::QUO_W-2:0], trial_ge};
            rem_reg <= trial_ge ? trial_sub[scp_pkg::ORDER_W-1:0]
                                : trial[scp_pkg::ORDER_W-1:0];
        end
        diag_reg <= quo_reg * scp_pkg::DIAG_W'(scp_pkg::DIAG_MUL);
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            start_x      <= pos_x_reg;
            start_y      <= pos_y_reg;
            end_x        <= pos_x_reg + $signed(dx);
            end_y        <= pos_y_reg + $signed(dy);
            direction    <= step_dir;
            last_segment <= step_last;
        end
    end

    assign status.active    = active_reg;
    assign status.div_last  = (div_cnt_reg == '0);
    assign status.can_push  = (level_reg < run_order_reg);
    assign status.top_done  = (level_reg != '0) &&
                              (top_entry.phase == scp_pkg::PHASE_LAST);
    assign status.step_last = step_last;

`ifndef NO_ASSERTIONS
    a_push_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> level_reg < scp_pkg::LVL_W'(scp_pkg::MAX_ORDER))
        else $error("push beyond stack depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> level_reg != '0)
        else $error("pop of empty stack");

    a_order_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (run_order_reg != '0) &&
                       (run_order_reg <= scp_pkg::LVL_W'(scp_pkg::MAX_ORDER)))
        else $error("latched order out of range");
`endif

endmodule

// ===== sv/scp_ctrl.sv =====
// ----------------------------------------------------------------------------
// scp_ctrl
// Sequencer: accept, divide, descend, unwind, emit.
// ----------------------------------------------------------------------------
module scp_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_restart,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  scp_pkg::scp_status_t  status,
    output scp_pkg::scp_cmd_t     cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_PUSH = 3'd2;
    localparam logic [2:0] S_POP  = 3'd3;
    localparam logic [2:0] S_STEP = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       emit_pend_reg;
    logic       emit_pend_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        emit_pend_next = emit_pend_reg;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_restart)
                    begin
                        cmd.start      = 1'b1;
                        emit_pend_next = 1'b1;
                        state_next     = S_DIV;
                    end
                    else if (status.active)
                        state_next = S_POP;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (status.can_push)
                    cmd.push = 1'b1;
                else if (emit_pend_reg)
                begin
                    emit_pend_next = 1'b0;
                    state_next     = S_POP;
                end
                else
                    state_next = S_IDLE;
            end
            S_POP:
            begin
                if (status.top_done)
                    cmd.pop = 1'b1;
                else
                    state_next = S_STEP;
            end
            S_STEP:
            begin
                if (out_free)
                begin
                    cmd.step   = 1'b1;
                    state_next = status.step_last ? S_IDLE : S_PUSH;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.step)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            emit_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            emit_pend_reg <= emit_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> out_free)
        else $error("segment written over an untaken result");
`endif

endmodule

// ===== sv/sierpinski_curve_segment_generator.sv =====
// Timing: an advance unwinds the finished levels, then emits its segment; a
//   restart runs the step divider, pushes the leaf path and then emits.
// Throughput: the stack moves one level per cycle; the sequencer takes no new
//   transfer until it is back in idle after pushing the next leaf path.
// Reset: idle, order 1, length 128; advances give no segment until a restart.
// ----------------------------------------------------------------------------
// sierpinski_curve_segment_generator
// Walks the closed Sierpinski curve of the configured order and emits one
// line segment per restart or in-curve advance, with an explicit type stack.
// ----------------------------------------------------------------------------
module sierpinski_curve_segment_generator
(
    input  logic                              clk,
    input  logic                              rst_n,
    scp_in_if.sink                            in_ch,
    scp_out_if.source                         out_ch,
    input  logic                              cfg_we,
    input  logic [scp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [scp_pkg::CFG_W-1:0]         cfg_wdata
);

    // Command and status between the sequencer and the datapath.
    scp_pkg::scp_cmd_t    cmd;
    scp_pkg::scp_status_t status;

    // The sequencer takes an input transfer only in its idle state. A
    // restart latches order and length, runs the divider for the step,
    // pushes the first leaf path and emits the first segment. An advance
    // unwinds finished levels, emits one move and pushes the path to the
    // next leaf. A finished segment waits in the output register while the
    // next transfer is already taken; only the emit step stalls on it.
    scp_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .in_restart (in_ch.restart),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Datapath: step = (length / 2) / order, axis moves of 2 * step and
    // diagonal moves of step * 181 in 8-bit fixed point; coordinates wrap.
    scp_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .status       (status),
        .start_x      (out_ch.start_x),
        .start_y      (out_ch.start_y),
        .end_x        (out_ch.end_x),
        .end_y        (out_ch.end_y),
        .direction    (out_ch.direction),
        .last_segment (out_ch.last_segment)
    );

endmodule
